[hdl/assert_macros.svh]
// Assertion macros used by the frame allocator sequencer.
// Assertions compile away when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define RFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// The expression must never be true outside reset.
`define RFA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define RFA_ASSERT(lbl, clk, rst_n, prop)
`define RFA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[hdl/rfa_pkg.sv]
// Shared constants, types and helpers of the reference-counted frame allocator.
// No dependencies; the files that use it refer to it by scoped names.
package rfa_pkg;

  localparam int unsigned FRAME_COUNT = 4096;
  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  typedef logic [IDX_W-1:0]       frame_idx_t;
  typedef logic [COUNT_WIDTH-1:0] use_count_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  localparam addr_t      POOL_BASE_RESET = 32'h1000_0000;
  localparam frame_idx_t LAST_IDX        = frame_idx_t'(FRAME_COUNT - 1);
  localparam use_count_t COUNT_MAX       = '1;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RETAIN  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_NOMEM   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_REPLY
  } state_t;

  // Read and write requests toward the count memory.
  typedef struct packed {
    logic       re;
    frame_idx_t addr;
  } ram_rd_t;

  typedef struct packed {
    logic       we;
    frame_idx_t addr;
    use_count_t data;
  } ram_wr_t;

  // Next frame index in the ring of frames.
  function automatic frame_idx_t wrap_inc(frame_idx_t i);
    frame_idx_t r;
    if (i == LAST_IDX) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

[hdl/rfa_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Depends on rfa_pkg for the address type.
interface rfa_cmd_if;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  rfa_pkg::addr_t      frame_address;

  modport source (output valid, command, frame_address, input ready);
  modport sink   (input valid, command, frame_address, output ready);
endinterface

interface rfa_rsp_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  rfa_pkg::addr_t      granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

[hdl/rfa_count_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rfa_count_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/rfa_ctrl.sv]
// Sequencer of the frame allocator: memory clear, command decode, read-modify-write,
// next-fit scan and the result register. Depends on rfa_pkg, rfa_if, assert_macros.svh.
`include "assert_macros.svh"

module rfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  rfa_pkg::addr_t      pool_base,
  rfa_cmd_if.sink             in_ch,
  rfa_rsp_if.source           out_ch,
  output rfa_pkg::ram_rd_t    ram_rd,
  output rfa_pkg::ram_wr_t    ram_wr,
  input  rfa_pkg::use_count_t ram_rdata
);

  rfa_pkg::state_t     state_r, state_nxt;
  rfa_pkg::frame_idx_t clr_idx_r, clr_idx_nxt;
  rfa_pkg::frame_idx_t idx_r, idx_nxt;
  rfa_pkg::frame_idx_t scan_cnt_r, scan_cnt_nxt;
  rfa_pkg::frame_idx_t next_index_r, next_index_nxt;
  logic                is_release_r, is_release_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  rfa_pkg::addr_t      res_addr_r, res_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  rfa_pkg::addr_t      out_addr_r, out_addr_nxt;

  rfa_pkg::addr_t      offset;
  logic                in_range;
  rfa_pkg::frame_idx_t lookup_idx;
  logic                in_ready;

  // Pool-relative frame number of the presented address.
  assign offset     = in_ch.frame_address - pool_base;
  assign in_range   = (32'(offset >> rfa_pkg::FRAME_SHIFT) < rfa_pkg::FRAME_COUNT);
  assign lookup_idx = offset[rfa_pkg::FRAME_SHIFT +: rfa_pkg::IDX_W];

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    idx_nxt        = idx_r;
    scan_cnt_nxt   = scan_cnt_r;
    next_index_nxt = next_index_r;
    is_release_nxt = is_release_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    in_ready       = 1'b0;
    ram_rd.re      = 1'b0;
    ram_rd.addr    = idx_r;
    ram_wr.we      = 1'b0;
    ram_wr.addr    = idx_r;
    ram_wr.data    = '0;

    case (state_r)
      rfa_pkg::ST_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = clr_idx_r;
        clr_idx_nxt = rfa_pkg::wrap_inc(clr_idx_r);
        if (clr_idx_r == rfa_pkg::LAST_IDX) begin
          state_nxt = rfa_pkg::ST_IDLE;
        end
      end

      rfa_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        is_release_nxt = (in_ch.command == rfa_pkg::CMD_RELEASE);
        if (in_ch.valid) begin
          if (in_ch.command == rfa_pkg::CMD_ALLOC) begin
            ram_rd.re    = 1'b1;
            ram_rd.addr  = next_index_r;
            idx_nxt      = next_index_r;
            scan_cnt_nxt = '0;
            state_nxt    = rfa_pkg::ST_SCAN;
          end else if ((in_ch.command == rfa_pkg::CMD_RETAIN ||
                        in_ch.command == rfa_pkg::CMD_RELEASE) && in_range) begin
            ram_rd.re   = 1'b1;
            ram_rd.addr = lookup_idx;
            idx_nxt     = lookup_idx;
            state_nxt   = rfa_pkg::ST_UPDATE;
          end else begin
            res_status_nxt = rfa_pkg::STATUS_INVALID;
            res_addr_nxt   = '0;
            state_nxt      = rfa_pkg::ST_REPLY;
          end
        end
      end

      rfa_pkg::ST_UPDATE: begin
        res_addr_nxt   = '0;
        res_status_nxt = rfa_pkg::STATUS_INVALID;
        if (is_release_r) begin
          if (ram_rdata != '0) begin
            ram_wr.we      = 1'b1;
            ram_wr.data    = ram_rdata - 1'b1;
            res_status_nxt = rfa_pkg::STATUS_OK;
          end
        end else if (ram_rdata != '0 && ram_rdata != rfa_pkg::COUNT_MAX) begin
          ram_wr.we      = 1'b1;
          ram_wr.data    = ram_rdata + 1'b1;
          res_status_nxt = rfa_pkg::STATUS_OK;
        end
        state_nxt = rfa_pkg::ST_REPLY;
      end

      rfa_pkg::ST_SCAN: begin
        // The read for the following frame is issued every cycle; it is simply
        // discarded when the current frame turns out to be free.
        ram_rd.re    = 1'b1;
        ram_rd.addr  = rfa_pkg::wrap_inc(idx_r);
        res_addr_nxt = '0;
        if (ram_rdata == '0) begin
          ram_wr.we      = 1'b1;
          ram_wr.data    = rfa_pkg::use_count_t'(1);
          next_index_nxt = idx_r;
          res_status_nxt = rfa_pkg::STATUS_OK;
          res_addr_nxt   = pool_base + (32'(idx_r) << rfa_pkg::FRAME_SHIFT);
          state_nxt      = rfa_pkg::ST_REPLY;
        end else if (scan_cnt_r == rfa_pkg::LAST_IDX) begin
          res_status_nxt = rfa_pkg::STATUS_NOMEM;
          state_nxt      = rfa_pkg::ST_REPLY;
        end else begin
          idx_nxt      = rfa_pkg::wrap_inc(idx_r);
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end

      rfa_pkg::ST_REPLY: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = rfa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rfa_pkg::ST_CLEAR;
      clr_idx_r    <= '0;
      next_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      next_index_r <= next_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    is_release_r <= is_release_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.granted_address = out_addr_r;

  `RFA_ASSERT(a_next_index_in_pool, clk, rst_n, 32'(next_index_r) < rfa_pkg::FRAME_COUNT)
  `RFA_ASSERT(a_accept_starts_work, clk, rst_n,
              (in_ch.valid && in_ch.ready) |=> state_r != rfa_pkg::ST_IDLE)
  `RFA_ASSERT(a_scan_write_ends, clk, rst_n,
              (state_r == rfa_pkg::ST_SCAN && ram_wr.we) |=> state_r == rfa_pkg::ST_REPLY)
  `RFA_ASSERT_NEVER(a_addr_only_on_ok, clk, rst_n,
                    out_valid_r && out_status_r != rfa_pkg::STATUS_OK && out_addr_r != '0)

endmodule

[hdl/refcounted_frame_allocator_top.sv]
// Order of work: a retain or release reads the use count and updates it, an invalid item goes
// straight to the result register, and an allocate scans frames in order from the frame last
// granted until it finds a free frame or has checked every frame and reports out of memory.
// A full output register adds stalls. Throughput: one item at a time; a new item is taken
// while the previous result waits. Reset: synchronous, active low; a clearing pass zeroes
// every use count, and no item is accepted until it ends. Config writes are taken outside reset.

module refcounted_frame_allocator_top (
  input  logic           clk,
  input  logic           rst_n,
  rfa_cmd_if.sink        in_ch,
  rfa_rsp_if.source      out_ch,
  input  logic           cfg_we,
  input  rfa_pkg::addr_t cfg_wdata
);

  // The pool base is used exactly as written, without alignment.
  rfa_pkg::addr_t      pool_base_r;

  rfa_pkg::ram_rd_t    ram_rd;
  rfa_pkg::ram_wr_t    ram_wr;
  rfa_pkg::use_count_t ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= rfa_pkg::POOL_BASE_RESET;
    end else if (cfg_we) begin
      pool_base_r <= cfg_wdata;
    end
  end

  // One use count per frame; zero marks a free frame.
  rfa_count_ram #(
    .DEPTH (rfa_pkg::FRAME_COUNT),
    .WIDTH (rfa_pkg::COUNT_WIDTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_rd.re),
    .raddr (ram_rd.addr),
    .rdata (ram_rdata)
  );

  // The sequencer owns all accesses to the memory, so a write always lands
  // before the read of the next item is issued.
  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .pool_base (pool_base_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_rd    (ram_rd),
    .ram_wr    (ram_wr),
    .ram_rdata (ram_rdata)
  );

endmodule
